FILE: hdl/tojq_pkg.sv
// shared types and constants for the time ordered job queue
package tojq_pkg;

  localparam int unsigned Depth    = 32;
  localparam int unsigned TimeBits = 20;
  localparam int unsigned TagBits  = 16;
  localparam int unsigned IdxBits  = $clog2(Depth);
  localparam int unsigned CntBits  = $clog2(Depth + 1);
  localparam int unsigned PosBits  = 8;
  localparam int unsigned CmdBits  = 3;
  localparam int unsigned StsBits  = 3;

  typedef enum logic [CmdBits-1:0] {
    CmdAdd    = 3'd0,
    CmdRemove = 3'd1,
    CmdPoll   = 3'd2,
    CmdList   = 3'd3,
    CmdTick   = 3'd4
  } cmd_e;

  typedef enum logic [StsBits-1:0] {
    StsAdded      = 3'd0,
    StsRemoved    = 3'd1,
    StsDispatched = 3'd2,
    StsNoneDue    = 3'd3,
    StsInvalid    = 3'd4,
    StsFull       = 3'd5,
    StsListed     = 3'd6
  } sts_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [TimeBits-1:0] start_time;
    logic [TagBits-1:0]  job_tag;
    logic [PosBits-1:0]  idx;
  } cmd_word_t;

  typedef struct packed {
    sts_e                status;
    logic                has_entry;
    logic [TimeBits-1:0] start_time;
    logic [TagBits-1:0]  job_tag;
    logic [PosBits-1:0]  position;
    logic                last;
  } res_word_t;

endpackage

FILE: hdl/tojq_front.sv
// front end: command intake and two-entry command queue
module tojq_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  tojq_pkg::cmd_word_t  word_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_take_i,
  output tojq_pkg::cmd_word_t  cmd_word_o
);

  tojq_pkg::cmd_word_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_pop      = cmd_take_i && cmd_valid_o;
  assign cmd_word_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: hdl/tojq_back.sv
// back end: sorted slot array, sequencer and result register
module tojq_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_take_o,
  input  tojq_pkg::cmd_word_t  cmd_word_i,
  output logic                 empty,
  input  logic                 pop,
  output tojq_pkg::res_word_t  res_o
);

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StList
  } state_e;

  localparam int unsigned D = tojq_pkg::Depth;

  state_e                            state_q, state_d;
  logic [tojq_pkg::TimeBits-1:0]     st_q [D];
  logic [tojq_pkg::TagBits-1:0]      tag_q [D];
  logic [tojq_pkg::CntBits-1:0]      count_q, count_d;
  logic [tojq_pkg::TimeBits-1:0]     ticks_q, ticks_d;
  tojq_pkg::cmd_word_t               cur_q;
  logic [D-1:0]                      le_q;
  logic [tojq_pkg::CntBits-1:0]      lix_q, lix_d;
  tojq_pkg::res_word_t               res_q, res_d;
  logic                              rvalid_q, rvalid_d;
  logic                              out_free;
  logic [tojq_pkg::CntBits-1:0]      ins_pos;
  logic [tojq_pkg::IdxBits-1:0]      lix;
  logic                              rm_ok;
  logic                              poll_ok;

  assign empty      = !rvalid_q;
  assign res_o      = res_q;
  assign out_free   = !rvalid_q || pop;
  assign cmd_take_o = (state_q == StIdle) && cmd_valid_i
                      && (out_free || cmd_word_i.cmd == tojq_pkg::CmdTick
                          || !(cmd_word_i.cmd inside {tojq_pkg::CmdAdd,
                          tojq_pkg::CmdRemove, tojq_pkg::CmdPoll, tojq_pkg::CmdList}));
  assign lix        = lix_q[tojq_pkg::IdxBits-1:0];
  assign rm_ok      = {{(8+1-tojq_pkg::CntBits){1'b0}}, count_q} > {1'b0, cmd_word_i.idx};
  assign poll_ok    = (count_q != '0) && (st_q[0] <= ticks_q);

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < D; i++) begin
      if (le_q[i] && (i < int'(count_q))) ins_pos = tojq_pkg::CntBits'(i + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_take_o && cmd_word_i.cmd == tojq_pkg::CmdAdd) begin
      for (int i = 0; i < D; i++) begin
        le_q[i] <= (st_q[i] <= cmd_word_i.start_time);
      end
    end
    if (cmd_take_o) cur_q <= cmd_word_i;
    if (state_q == StSearch && out_free) begin
      for (int i = 0; i < D; i++) begin
        if (i > int'(ins_pos)) begin
          st_q[i]  <= st_q[i-1];
          tag_q[i] <= tag_q[i-1];
        end else if (i == int'(ins_pos)) begin
          st_q[i]  <= cur_q.start_time;
          tag_q[i] <= cur_q.job_tag;
        end
      end
    end else if (state_q == StIdle && cmd_take_o
                 && ((cmd_word_i.cmd == tojq_pkg::CmdRemove && rm_ok)
                     || (cmd_word_i.cmd == tojq_pkg::CmdPoll && poll_ok))) begin
      for (int i = 0; i < D - 1; i++) begin
        if (cmd_word_i.cmd == tojq_pkg::CmdPoll || i >= int'(cmd_word_i.idx)) begin
          st_q[i]  <= st_q[i+1];
          tag_q[i] <= tag_q[i+1];
        end
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ticks_d  = ticks_q;
    lix_d    = lix_q;
    res_d    = res_q;
    rvalid_d = rvalid_q && !pop;
    case (state_q)
      StIdle: begin
        if (cmd_take_o) begin
          case (cmd_word_i.cmd)
            tojq_pkg::CmdAdd: begin
              if (count_q == tojq_pkg::CntBits'(D)) begin
                res_d        = '0;
                res_d.status = tojq_pkg::StsFull;
                res_d.last   = 1'b1;
                rvalid_d     = 1'b1;
              end else begin
                state_d = StSearch;
              end
            end
            tojq_pkg::CmdRemove: begin
              res_d      = '0;
              res_d.last = 1'b1;
              rvalid_d   = 1'b1;
              if (rm_ok) begin
                res_d.status     = tojq_pkg::StsRemoved;
                res_d.has_entry  = 1'b1;
                res_d.start_time = st_q[cmd_word_i.idx[tojq_pkg::IdxBits-1:0]];
                res_d.job_tag    = tag_q[cmd_word_i.idx[tojq_pkg::IdxBits-1:0]];
                res_d.position   = cmd_word_i.idx;
                count_d          = count_q - 1'b1;
              end else begin
                res_d.status = tojq_pkg::StsInvalid;
              end
            end
            tojq_pkg::CmdPoll: begin
              res_d      = '0;
              res_d.last = 1'b1;
              rvalid_d   = 1'b1;
              if (poll_ok) begin
                res_d.status     = tojq_pkg::StsDispatched;
                res_d.has_entry  = 1'b1;
                res_d.start_time = st_q[0];
                res_d.job_tag    = tag_q[0];
                count_d          = count_q - 1'b1;
              end else begin
                res_d.status = tojq_pkg::StsNoneDue;
              end
            end
            tojq_pkg::CmdList: begin
              if (count_q == '0) begin
                res_d        = '0;
                res_d.status = tojq_pkg::StsListed;
                res_d.last   = 1'b1;
                rvalid_d     = 1'b1;
              end else begin
                lix_d   = '0;
                state_d = StList;
              end
            end
            tojq_pkg::CmdTick: begin
              if (ticks_q != '1) ticks_d = ticks_q + 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      StSearch: begin
        if (out_free) begin
          res_d.status     = tojq_pkg::StsAdded;
          res_d.has_entry  = 1'b1;
          res_d.start_time = cur_q.start_time;
          res_d.job_tag    = cur_q.job_tag;
          res_d.position   = tojq_pkg::PosBits'(ins_pos);
          res_d.last       = 1'b1;
          rvalid_d         = 1'b1;
          count_d          = count_q + 1'b1;
          state_d          = StIdle;
        end
      end
      StList: begin
        if (out_free) begin
          res_d.status     = tojq_pkg::StsListed;
          res_d.has_entry  = 1'b1;
          res_d.start_time = st_q[lix];
          res_d.job_tag    = tag_q[lix];
          res_d.position   = tojq_pkg::PosBits'(lix_q);
          res_d.last       = (lix_q + 1'b1 == count_q);
          rvalid_d         = 1'b1;
          lix_d            = lix_q + 1'b1;
          if (lix_q + 1'b1 == count_q) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      ticks_q  <= '0;
      lix_q    <= '0;
      rvalid_q <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ticks_q  <= ticks_d;
      lix_q    <= lix_d;
      rvalid_q <= rvalid_d;
      res_q    <= res_d;
    end
  end

endmodule

FILE: hdl/time_ordered_job_queue_unit.sv
// top level of the time ordered job queue
// Keeps up to 32 jobs sorted by start time, equal times in arrival order.
// Commands enter through a two-word queue; the back end takes one at a time. Remove and
// poll put their result word out in the cycle after being taken, tick and unused codes
// give no word, add works in two steps (a parallel compare of all slots, then a shift
// and write once the result register is free; if full, a full word), and list gives
// one word per cycle for each entry while the result register is free (a single word
// if empty). A command that gives a result is not taken while an earlier word waits to
// be popped, so a held result stalls the back end, fills the queue and raises full.
module time_ordered_job_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  command_i,
  input  logic [19:0] start_time_i,
  input  logic [15:0] job_tag_i,
  input  logic [7:0]  remove_index_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic        has_entry_o,
  output logic [19:0] out_start_time_o,
  output logic [15:0] out_job_tag_o,
  output logic [7:0]  position_o,
  output logic        last_o
);

  tojq_pkg::cmd_word_t in_word, cmd_word;
  tojq_pkg::res_word_t res;
  logic cmd_valid, cmd_take;

  assign in_word.cmd        = tojq_pkg::cmd_e'(command_i);
  assign in_word.start_time = start_time_i;
  assign in_word.job_tag    = job_tag_i;
  assign in_word.idx        = remove_index_i;

  tojq_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .word_i      (in_word),
    .cmd_valid_o (cmd_valid),
    .cmd_take_i  (cmd_take),
    .cmd_word_o  (cmd_word)
  );

  tojq_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_take_o  (cmd_take),
    .cmd_word_i  (cmd_word),
    .empty, .pop,
    .res_o       (res)
  );

  assign status_o         = res.status;
  assign has_entry_o      = res.has_entry;
  assign out_start_time_o = res.start_time;
  assign out_job_tag_o    = res.job_tag;
  assign position_o       = res.position;
  assign last_o           = res.last;

endmodule
